// ===== rtl/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared sizes, operation codes and item types of the max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;

  // index of one heap slot, and a count that can hold CAPACITY itself
  localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] top_value;
    logic        heap_empty;
    logic [6:0]  entry_count;
  } out_t;

endpackage

// ===== rtl/max_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap in a synchronous memory with registered reads; push, pop and clear.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result shows on
// out_item for one cycle with out_valid, in the cycle after the operation
// ends, and must be captured then. Each tree level waits on the memory's
// registered read: a push into an empty heap finishes from S_IDLE, and any
// other push climbs level by level in S_UP_CMP, with S_UP_WR if it reaches
// the root; a pop that empties the heap finishes from S_IDLE, one that leaves
// a single entry in S_DN_LAST, and any other pop descends in S_DN_CMP, with
// S_DN_WR if it reaches a leaf; a clear, a refused push or pop and an unknown
// kind finish from S_IDLE. The root value is also held in a register so the
// top is reported without an extra read. No clearing pass after reset.
module max_heap_priority_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  mhpq_pkg::in_t  in_item,
  output logic           out_valid,
  output mhpq_pkg::out_t out_item
);
  import mhpq_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_CMP  = 3'd1;
  localparam logic [2:0] S_UP_WR   = 3'd2;
  localparam logic [2:0] S_DN_LAST = 3'd3;
  localparam logic [2:0] S_DN_CMP  = 3'd4;
  localparam logic [2:0] S_DN_WR   = 3'd5;

  logic [VALUE_WIDTH-1:0] heap_mem [CAPACITY];

  logic [2:0]             state_r,  state_nxt;
  logic [IDX_W-1:0]       pos_r,    pos_nxt;
  logic [VALUE_WIDTH-1:0] v_r,      v_nxt;
  logic [CNT_W-1:0]       count_r,  count_nxt;
  logic [VALUE_WIDTH-1:0] top_r,    top_nxt;
  logic                   out_valid_r;
  out_t                   out_r,    out_nxt;

  logic                   we;
  logic [IDX_W-1:0]       waddr, raddr_a, raddr_b;
  logic [VALUE_WIDTH-1:0] wdata, rdata_a, rdata_b;

  logic                   fin, ok;
  logic [VALUE_WIDTH+31:0] val_ext, top_ext;
  logic [VALUE_WIDTH-1:0] val_in, top_sel, big_val;
  logic [CNT_W+6:0]       cnt_ext;
  logic [IDX_W+1:0]       n_ext, left_w, right_w, cl_w, cr_w;
  logic [IDX_W-1:0]       up_idx, big_idx;
  logic                   pick_right;

  // reads only ever reach nodes on the path ahead of the write pointer,
  // never a slot written earlier in the same operation: no forwarding
  always_ff @(posedge clk) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
    rdata_a <= heap_mem[raddr_a];
    rdata_b <= heap_mem[raddr_b];
  end

  assign val_ext = {{VALUE_WIDTH{1'b0}}, in_item.value};
  assign val_in  = val_ext[VALUE_WIDTH-1:0];

  assign n_ext   = (IDX_W + 2)'(count_r);
  assign left_w  = {1'b0, pos_r, 1'b1};
  assign right_w = left_w + 1'b1;
  assign up_idx  = (pos_r - 1'b1) >> 1;

  assign pick_right = (right_w < n_ext) && (rdata_b > rdata_a);
  assign big_val    = pick_right ? rdata_b : rdata_a;
  assign big_idx    = pick_right ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];
  assign cl_w       = {1'b0, big_idx, 1'b1};
  assign cr_w       = cl_w + 1'b1;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    v_nxt     = v_r;
    count_nxt = count_r;
    top_nxt   = top_r;
    we        = 1'b0;
    waddr     = pos_r;
    wdata     = v_r;
    raddr_a   = '0;
    raddr_b   = '0;
    fin       = 1'b0;
    ok        = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_item.kind)
            KIND_PUSH: begin
              if (count_r >= CNT_W'(CAPACITY)) begin
                fin = 1'b1;
                ok  = 1'b0;
              end else if (count_r == '0) begin
                we        = 1'b1;
                waddr     = '0;
                wdata     = val_in;
                count_nxt = CNT_W'(1);
                fin       = 1'b1;
              end else begin
                v_nxt     = val_in;
                pos_nxt   = IDX_W'(count_r);
                raddr_a   = IDX_W'((count_r - 1'b1) >> 1);
                state_nxt = S_UP_CMP;
              end
            end
            KIND_POP: begin
              if (count_r == '0) begin
                fin = 1'b1;
                ok  = 1'b0;
              end else begin
                count_nxt = count_r - 1'b1;
                raddr_a   = IDX_W'(count_r - 1'b1);
                if (count_r == CNT_W'(1)) begin
                  fin = 1'b1;
                end else begin
                  state_nxt = S_DN_LAST;
                end
              end
            end
            KIND_CLEAR: begin
              count_nxt = '0;
              fin       = 1'b1;
            end
            default: begin
              fin = 1'b1;
              ok  = 1'b0;
            end
          endcase
        end
      end

      S_UP_CMP: begin
        we = 1'b1;
        if (v_r < rdata_a) begin
          count_nxt = count_r + 1'b1;
          fin       = 1'b1;
        end else begin
          wdata   = rdata_a;
          pos_nxt = up_idx;
          if (up_idx == '0) begin
            state_nxt = S_UP_WR;
          end else begin
            raddr_a = (up_idx - 1'b1) >> 1;
          end
        end
      end

      S_UP_WR: begin
        we        = 1'b1;
        count_nxt = count_r + 1'b1;
        fin       = 1'b1;
      end

      S_DN_LAST: begin
        // last entry arrives; it becomes the sifting value at the root
        v_nxt   = rdata_a;
        pos_nxt = '0;
        if (n_ext <= (IDX_W + 2)'(1)) begin
          we    = 1'b1;
          waddr = '0;
          wdata = rdata_a;
          fin   = 1'b1;
        end else begin
          raddr_a   = IDX_W'(1);
          raddr_b   = IDX_W'(2);
          state_nxt = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        we = 1'b1;
        if (!(v_r < big_val)) begin
          fin = 1'b1;
        end else begin
          wdata   = big_val;
          pos_nxt = big_idx;
          if (cl_w >= n_ext) begin
            state_nxt = S_DN_WR;
          end else begin
            raddr_a = cl_w[IDX_W-1:0];
            raddr_b = cr_w[IDX_W-1:0];
          end
        end
      end

      S_DN_WR: begin
        we  = 1'b1;
        fin = 1'b1;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (we && (waddr == '0)) begin
      top_nxt = wdata;
    end
    if (fin) begin
      state_nxt = S_IDLE;
    end
  end

  assign top_sel = (count_nxt == '0) ? '0 : top_nxt;
  assign top_ext = {32'd0, top_sel};
  assign cnt_ext = {7'd0, count_nxt};

  always_comb begin
    out_nxt.accepted    = ok;
    out_nxt.top_value   = top_ext[31:0];
    out_nxt.heap_empty  = (count_nxt == '0);
    out_nxt.entry_count = cnt_ext[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    v_r   <= v_nxt;
    top_r <= top_nxt;
    if (fin) begin
      out_r <= out_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== rtl/mhpq_checker.sv =====
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks of the max-heap priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module mhpq_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input mhpq_pkg::in_t  in_item,
  input logic           out_valid,
  input mhpq_pkg::out_t out_item
);
  import mhpq_pkg::*;

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  // a result comes out once the operation has ended, so the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.heap_empty == (out_item.entry_count == 7'd0)))
    else $error("empty flag disagrees with count");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.heap_empty |-> out_item.top_value == 32'd0)
    else $error("nonzero top on empty heap");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_item.kind == KIND_CLEAR) |=>
      out_valid && out_item.accepted && out_item.heap_empty)
    else $error("clear not reported at once");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the max-heap priority queue: a directed opener
// through the empty, equal-value and extreme-value cases, then randomized
// fill, drain and mixed traffic, all checked against a behavioral heap.
// ----------------------------------------------------------------------------
module tb_top;
  import mhpq_pkg::*;

  // kind code with no operation behind it; the block must refuse it and leave the heap as it is
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1100;
  localparam int SETTLE_CYCLES = 16;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_RANDOM} traffic_t;

  class heap_scoreboard;
    logic [31:0] slots [CAPACITY];
    int          depth;
    out_t        pending_results [$];
    int          mismatches;
    int          checked;
    int          n_push, n_pop, n_clear, n_ignored, n_refused, n_full_refused, peak;

    function int pending();
      return pending_results.size();
    endfunction

    // apply one item that the block takes to the heap and queue the state it leaves
    function void note_item(in_t it);
      out_t        res;
      logic        ok;
      int          pos, up, lft, rgt, big;
      logic [31:0] tmp;
      ok = 1'b0;
      case (it.kind)
        KIND_PUSH: begin
          n_push++;
          if (depth < CAPACITY) begin
            pos = depth;
            slots[pos] = it.value;
            // an equal parent does not stop the climb
            while (pos > 0) begin
              up = (pos - 1) / 2;
              if (slots[pos] < slots[up]) break;
              tmp = slots[pos];
              slots[pos] = slots[up];
              slots[up] = tmp;
              pos = up;
            end
            depth++;
            ok = 1'b1;
          end else begin
            n_refused++;
            n_full_refused++;
          end
        end
        KIND_POP: begin
          n_pop++;
          if (depth > 0) begin
            slots[0] = slots[depth - 1];
            depth--;
            pos = 0;
            while (1) begin
              lft = 2 * pos + 1;
              rgt = 2 * pos + 2;
              if (lft >= depth) break;
              big = lft;
              if (rgt < depth && slots[rgt] > slots[lft]) big = rgt;
              if (!(slots[pos] < slots[big])) break;
              tmp = slots[pos];
              slots[pos] = slots[big];
              slots[big] = tmp;
              pos = big;
            end
            ok = 1'b1;
          end else begin
            n_refused++;
          end
        end
        KIND_CLEAR: begin
          n_clear++;
          depth = 0;
          ok = 1'b1;
        end
        default: n_ignored++;
      endcase
      if (depth > peak) peak = depth;
      res.accepted    = ok;
      res.heap_empty  = (depth == 0);
      res.top_value   = (depth == 0) ? 32'd0 : slots[0];
      res.entry_count = depth[6:0];
      pending_results.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t want;
      checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $time, got);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.accepted !== want.accepted) begin
        $display("%0t: accepted expected %0d actual %0d", $time, want.accepted, got.accepted);
        mismatches++;
      end
      if (got.top_value !== want.top_value) begin
        $display("%0t: top_value expected %h actual %h", $time, want.top_value, got.top_value);
        mismatches++;
      end
      if (got.heap_empty !== want.heap_empty) begin
        $display("%0t: heap_empty expected %0d actual %0d", $time, want.heap_empty,
                 got.heap_empty);
        mismatches++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                 got.entry_count);
        mismatches++;
      end
    endfunction
  endclass

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  in_t            in_item;
  logic           out_valid;
  out_t           out_item;
  heap_scoreboard sb;

  max_heap_priority_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_item(in_item);
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  // hold the item until the block takes it; start stays high for a follow-on
  task automatic send_item(in_t it);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic in_t make_item(logic [1:0] kind, logic [31:0] value);
    in_t it;
    it.kind  = kind;
    it.value = value;
    return it;
  endfunction

  function automatic logic [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return 32'd0;
    if (roll == 1) return 32'hFFFF_FFFF;
    if (roll < 6) return $urandom_range(0, 7);  // many ties
    return $urandom;
  endfunction

  function automatic in_t pick_op(traffic_t mode);
    in_t it;
    int  roll, push_pct;
    roll     = $urandom_range(0, 199);
    it.value = pick_value();
    case (mode)
      MIX_FILL:  push_pct = 85;
      MIX_DRAIN: push_pct = 15;
      default:   push_pct = 55;
    endcase
    if (roll < 3) it.kind = KIND_UNUSED;
    else if (roll < 4 || (mode == MIX_RANDOM && roll < 8)) it.kind = KIND_CLEAR;
    else it.kind = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
    return it;
  endfunction

  task automatic run_random(int target);
    int       done, phase_left, burst;
    traffic_t mode;
    in_t      it;
    done       = 0;
    phase_left = 0;
    burst      = 0;
    mode       = MIX_FILL;
    while (done < target) begin
      if (phase_left == 0) begin
        mode       = traffic_t'($urandom_range(0, 2));
        phase_left = $urandom_range(30, 140);
        if ($urandom_range(0, 3) == 0) wait_all_results();
      end
      it = pick_op(mode);
      send_item(it);
      if (it.kind != KIND_UNUSED) begin
        done++;
        phase_left--;
      end
      if (burst == 0) begin
        // long gap-free stretches now and then
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
        idle_cycles($urandom_range(1, 10));
      end else begin
        burst--;
      end
    end
  endtask

  initial begin
    in_t opener [$];
    sb      = new();
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty-heap refusals, ties, extremes, ignored kind, clear and refill
    opener = '{make_item(KIND_CLEAR, 32'h0),        make_item(KIND_POP, 32'hFFFF_FFFF),
               make_item(KIND_UNUSED, 32'h1234_5678), make_item(KIND_PUSH, 32'd5),
               make_item(KIND_PUSH, 32'd5),          make_item(KIND_PUSH, 32'd0),
               make_item(KIND_PUSH, 32'hFFFF_FFFF),  make_item(KIND_PUSH, 32'd7),
               make_item(KIND_UNUSED, 32'hFFFF_FFFF), make_item(KIND_POP, 32'h0),
               make_item(KIND_POP, 32'h0),           make_item(KIND_PUSH, 32'h8000_0000),
               make_item(KIND_PUSH, 32'd1),          make_item(KIND_PUSH, 32'hFFFF_FFFF),
               make_item(KIND_PUSH, 32'hFFFF_FFFF),  make_item(KIND_POP, 32'h0),
               make_item(KIND_POP, 32'h0),           make_item(KIND_CLEAR, 32'h5555_5555),
               make_item(KIND_POP, 32'h0),           make_item(KIND_PUSH, 32'h0),
               make_item(KIND_POP, 32'h0),           make_item(KIND_POP, 32'h0)};
    foreach (opener[i]) begin
      send_item(opener[i]);
      if (i % 5 == 4) idle_cycles($urandom_range(1, 6));
    end
    wait_all_results();

    run_random(RANDOM_ITEMS);

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d pushes, %0d pops, %0d clears, %0d ignored kinds, peak depth %0d",
             sb.n_push, sb.n_pop, sb.n_clear, sb.n_ignored, sb.peak);
    $display("%0d refused (%0d on a full heap), %0d results checked, %0d mismatches",
             sb.n_refused, sb.n_full_refused, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout waiting for results");
    $display("status: fail");
    $finish;
  end

endmodule

// ===== max_heap_priority_queue.f =====
rtl/mhpq_pkg.sv
rtl/max_heap_priority_queue.sv
rtl/mhpq_checker.sv
tb/tb_top.sv
